// ===== src/pdm_pkg.sv =====
package pdm_pkg;

  // busy/done handshake reported by the shared arithmetic units
  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

  localparam int IN_W      = 32;
  localparam int STEP_W    = 31;
  localparam int LIMIT_W   = 31;
  localparam int CFG_IDX_W = 3;
  localparam int MUL_CHUNK = 16;

  localparam logic [CFG_IDX_W-1:0] REG_GAIN_P        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_I        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_D        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WINDUP_LIMIT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DRIVE_FLOOR   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DRIVE_CEILING = 3'd5;

  localparam logic CMD_CLEAR = 1'b1;

endpackage

// ===== src/pdm_req_if.sv =====
interface pdm_req_if;
  logic                               valid;
  logic                               ready;
  logic                               cmd;
  logic signed [pdm_pkg::IN_W-1:0]    target;
  logic signed [pdm_pkg::IN_W-1:0]    sensed;
  logic        [pdm_pkg::STEP_W-1:0]  step_time;

  modport source (output valid, cmd, target, sensed, step_time, input ready);
  modport sink (input valid, cmd, target, sensed, step_time, output ready);
endinterface

// ===== src/pdm_rsp_if.sv =====
interface pdm_rsp_if;
  logic                            valid;
  logic                            ready;
  logic signed [pdm_pkg::IN_W-1:0] drive;
  logic signed [pdm_pkg::IN_W-1:0] integral_now;
  logic                            zero_step_fault;

  modport source (output valid, drive, integral_now, zero_step_fault, input ready);
  modport sink (input valid, drive, integral_now, zero_step_fault, output ready);
endinterface

// ===== src/pdm_cfg_if.sv =====
interface pdm_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [pdm_pkg::CFG_IDX_W-1:0]      index;
  logic [pdm_pkg::IN_W-1:0]           data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== src/pid_derivative_on_measurement.sv =====
// PID regulator in signed fixed point (FRAC_BITS fraction bits, values held at DATA_WIDTH
// bits and saturated there), derivative taken on the measurement. A compute beat runs four
// products through one shared multiplier that takes 16 multiplier bits per cycle, then one
// quotient through a divider that makes one bit per cycle; the block takes no new beat until
// the result is handed to the output register. The derivative product and the divider
// pass are skipped when step_time is zero. Configuration writes are taken in any cycle and
// must only come while idle.
module pid_derivative_on_measurement #(
  parameter int FRAC_BITS  = 16,
  parameter int DATA_WIDTH = 32
) (
  input logic       clk,
  input logic       rst,
  pdm_req_if.sink   req,
  pdm_rsp_if.source rsp,
  pdm_cfg_if.sink   cfg
);
  import pdm_pkg::*;

  localparam int DW = DATA_WIDTH;
  localparam int OW = (DW > 32) ? DW : 32;
  localparam int SW = OW + 2;

  localparam logic signed [SW-1:0] MAXV = {{(SW-DW+1){1'b0}}, {(DW-1){1'b1}}};
  localparam logic signed [SW-1:0] MINV = {{(SW-DW+1){1'b1}}, {(DW-1){1'b0}}};

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_P_GO  = 4'd1;
  localparam logic [3:0] ST_P_WT  = 4'd2;
  localparam logic [3:0] ST_I_GO  = 4'd3;
  localparam logic [3:0] ST_I_WT  = 4'd4;
  localparam logic [3:0] ST_IT_GO = 4'd5;
  localparam logic [3:0] ST_IT_WT = 4'd6;
  localparam logic [3:0] ST_D_GO  = 4'd7;
  localparam logic [3:0] ST_D_WT  = 4'd8;
  localparam logic [3:0] ST_V_WT  = 4'd9;
  localparam logic [3:0] ST_SUM   = 4'd10;
  localparam logic [3:0] ST_SUM2  = 4'd11;
  localparam logic [3:0] ST_OUT   = 4'd12;

  function automatic logic signed [SW-1:0] widen(input logic signed [DW-1:0] x);
    return {{(SW-DW){x[DW-1]}}, x};
  endfunction

  function automatic logic signed [DW-1:0] sat_dw(input logic signed [SW-1:0] x);
    if (x > MAXV) return MAXV[DW-1:0];
    if (x < MINV) return MINV[DW-1:0];
    return x[DW-1:0];
  endfunction

  function automatic logic signed [DW-1:0] from32(input logic [IN_W-1:0] v);
    return sat_dw({{(SW-IN_W){v[IN_W-1]}}, v});
  endfunction

  function automatic logic signed [DW-1:0] clamp_int(input logic signed [DW-1:0] x,
                                                     input logic [LIMIT_W-1:0] w);
    logic signed [SW-1:0] xe;
    logic signed [SW-1:0] we;
    logic signed [SW-1:0] wn;
    xe = widen(x);
    we = {{(SW-LIMIT_W){1'b0}}, w};
    wn = -we;
    if (xe > we) return we[DW-1:0];
    if (xe < wn) return wn[DW-1:0];
    return x;
  endfunction

  // configuration
  logic signed [DW-1:0] gain_p;
  logic signed [DW-1:0] gain_i;
  logic signed [DW-1:0] gain_d;
  logic [LIMIT_W-1:0]   windup_limit;
  logic signed [DW-1:0] drive_floor;
  logic signed [DW-1:0] drive_ceiling;

  // state and working registers
  logic [3:0]           state;
  logic signed [DW-1:0] integral_acc;
  logic signed [DW-1:0] last_sensed;
  logic signed [DW-1:0] err;
  logic signed [DW-1:0] dsens;
  logic [STEP_W-1:0]    dt;
  logic                 fault;
  logic signed [DW-1:0] p;
  logic signed [DW-1:0] it;
  logic signed [DW-1:0] d;
  logic signed [DW-1:0] s1;
  logic signed [DW-1:0] res_drive;

  // shared units
  logic                 mul_start;
  logic signed [OW-1:0] mul_a;
  logic signed [OW-1:0] mul_b;
  unit_stat_t           mul_stat;
  logic signed [DW-1:0] mul_res;
  logic                 div_start;
  logic signed [DW-1:0] div_num;
  unit_stat_t           div_stat;
  logic signed [DW-1:0] div_res;

  logic signed [DW-1:0] in_target;
  logic signed [DW-1:0] in_sensed;
  logic signed [DW-1:0] int_next;
  logic signed [DW-1:0] sum2;
  logic signed [DW-1:0] sum_clamped;
  logic signed [SW-1:0] drive_w;
  logic signed [SW-1:0] integ_w;
  logic signed [SW-1:0] int_w;
  logic signed [SW-1:0] lim_w;
  logic                 int_in_bounds;

  pdm_mul #(.OW(OW), .DW(DW), .FRAC_BITS(FRAC_BITS)) u_mul (
    .clk    (clk),
    .rst    (rst),
    .start  (mul_start),
    .a      (mul_a),
    .b      (mul_b),
    .stat   (mul_stat),
    .result (mul_res)
  );

  pdm_div #(.DW(DW), .FRAC_BITS(FRAC_BITS)) u_div (
    .clk    (clk),
    .rst    (rst),
    .start  (div_start),
    .num    (div_num),
    .den    (dt),
    .stat   (div_stat),
    .result (div_res)
  );

  assign req.ready = (state == ST_IDLE);
  assign cfg.ready = 1'b1;

  assign in_target = from32(req.target);
  assign in_sensed = from32(req.sensed);

  assign mul_start = (state == ST_P_GO) || (state == ST_I_GO) ||
                     (state == ST_IT_GO) || (state == ST_D_GO);

  always_comb begin
    unique case (state)
      ST_P_GO: begin
        mul_a = OW'(widen(gain_p));
        mul_b = OW'(widen(err));
      end
      ST_I_GO: begin
        mul_a = OW'(widen(err));
        mul_b = {{(OW-STEP_W){1'b0}}, dt};
      end
      ST_IT_GO: begin
        mul_a = OW'(widen(gain_i));
        mul_b = OW'(widen(integral_acc));
      end
      ST_D_GO: begin
        mul_a = OW'(widen(gain_d));
        mul_b = OW'(widen(dsens));
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // derivative term is the negated product over the step
  assign div_start = (state == ST_D_WT) && mul_stat.done;
  assign div_num   = sat_dw(-widen(mul_res));

  assign int_next = clamp_int(sat_dw(widen(integral_acc) + widen(mul_res)), windup_limit);
  assign sum2     = sat_dw(widen(s1) + widen(d));

  // when the limits are crossed, a sum above the ceiling takes the ceiling and any other takes the floor
  always_comb begin
    if (sum2 > drive_ceiling) begin
      sum_clamped = drive_ceiling;
    end else if (sum2 < drive_floor) begin
      sum_clamped = drive_floor;
    end else begin
      sum_clamped = sum2;
    end
  end

  assign drive_w       = widen(res_drive);
  assign integ_w       = widen(integral_acc);
  assign int_w         = integ_w;
  assign lim_w         = {{(SW-LIMIT_W){1'b0}}, windup_limit};
  assign int_in_bounds = (int_w <= lim_w) && (int_w >= -lim_w);

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      rsp.valid     <= 1'b0;
      integral_acc  <= '0;
      last_sensed   <= '0;
      gain_p        <= '0;
      gain_i        <= '0;
      gain_d        <= '0;
      windup_limit  <= {LIMIT_W{1'b1}};
      drive_floor   <= MINV[DW-1:0];
      drive_ceiling <= MAXV[DW-1:0];
    end else begin
      if (rsp.valid && rsp.ready && (state != ST_OUT)) rsp.valid <= 1'b0;

      unique case (state)
        ST_IDLE: begin
          if (req.valid && req.ready) begin
            if (req.cmd == CMD_CLEAR) begin
              integral_acc <= '0;
              last_sensed  <= '0;
              res_drive    <= '0;
              fault        <= 1'b0;
              state        <= ST_OUT;
            end else begin
              err         <= sat_dw(widen(in_target) - widen(in_sensed));
              dsens       <= sat_dw(widen(in_sensed) - widen(last_sensed));
              last_sensed <= in_sensed;
              dt          <= req.step_time;
              fault       <= (req.step_time == '0);
              state       <= ST_P_GO;
            end
          end
        end
        ST_P_GO:  state <= ST_P_WT;
        ST_P_WT: begin
          if (mul_stat.done) begin
            p     <= mul_res;
            state <= ST_I_GO;
          end
        end
        ST_I_GO:  state <= ST_I_WT;
        ST_I_WT: begin
          if (mul_stat.done) begin
            integral_acc <= int_next;
            state        <= ST_IT_GO;
          end
        end
        ST_IT_GO: state <= ST_IT_WT;
        ST_IT_WT: begin
          if (mul_stat.done) begin
            it <= mul_res;
            if (fault) begin
              d     <= '0;
              state <= ST_SUM;
            end else begin
              state <= ST_D_GO;
            end
          end
        end
        ST_D_GO:  state <= ST_D_WT;
        ST_D_WT: begin
          if (mul_stat.done) state <= ST_V_WT;
        end
        ST_V_WT: begin
          if (div_stat.done) begin
            d     <= div_res;
            state <= ST_SUM;
          end
        end
        ST_SUM: begin
          s1    <= sat_dw(widen(p) + widen(it));
          state <= ST_SUM2;
        end
        ST_SUM2: begin
          res_drive <= sum_clamped;
          state     <= ST_OUT;
        end
        ST_OUT: begin
          if (!rsp.valid || rsp.ready) begin
            rsp.valid           <= 1'b1;
            rsp.drive           <= drive_w[IN_W-1:0];
            rsp.integral_now    <= integ_w[IN_W-1:0];
            rsp.zero_step_fault <= fault;
            state               <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase

      if (cfg.valid && cfg.ready) begin
        unique case (cfg.index)
          REG_GAIN_P:        gain_p        <= from32(cfg.data);
          REG_GAIN_I:        gain_i        <= from32(cfg.data);
          REG_GAIN_D:        gain_d        <= from32(cfg.data);
          REG_WINDUP_LIMIT: begin
            windup_limit <= cfg.data[LIMIT_W-1:0];
            integral_acc <= clamp_int(integral_acc, cfg.data[LIMIT_W-1:0]);
          end
          REG_DRIVE_FLOOR:   drive_floor   <= from32(cfg.data);
          REG_DRIVE_CEILING: drive_ceiling <= from32(cfg.data);
          default: ;
        endcase
      end
    end
  end

  a_mul_free: assert property (@(posedge clk) disable iff (rst)
    mul_start |-> !mul_stat.busy)
    else $error("multiplier started while busy");

  a_div_den: assert property (@(posedge clk) disable iff (rst)
    div_start |-> (dt != '0) && !div_stat.busy)
    else $error("divider started with zero step or while busy");

  a_int_bound: assert property (@(posedge clk) disable iff (rst)
    int_in_bounds)
    else $error("integral outside windup limit");

  a_rsp_load: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp.valid) |-> $past(state) == ST_OUT)
    else $error("result beat raised outside the output step");

endmodule

// ===== src/pdm_mul.sv =====
module pdm_mul #(
  parameter int OW        = 32,
  parameter int DW        = 32,
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic signed [OW-1:0] a,
  input  logic signed [OW-1:0] b,
  output pdm_pkg::unit_stat_t  stat,
  output logic signed [DW-1:0] result
);
  import pdm_pkg::*;

  localparam int CH  = MUL_CHUNK;
  localparam int NCH = (OW + CH - 1) / CH;
  localparam int BW  = NCH * CH;
  localparam int PW  = OW + BW;
  localparam int CW  = $clog2(NCH + 1);

  localparam logic [1:0] M_IDLE = 2'd0;
  localparam logic [1:0] M_RUN  = 2'd1;
  localparam logic [1:0] M_FIN  = 2'd2;

  localparam logic [PW:0] RND = (PW+1)'((1 << FRAC_BITS) - 1);

  logic [1:0]         mstate;
  logic [OW-1:0]      ma;
  logic [BW-1:0]      mb;
  logic               neg;
  logic [PW-1:0]      acc;
  logic [CW-1:0]      cnt;
  logic               done;

  logic [OW-1:0]      a_mag;
  logic [OW-1:0]      b_mag;
  logic [OW+CH-1:0]   pp;
  logic [PW:0]        rnd;
  logic [PW:0]        q;
  logic               over;
  logic signed [DW-1:0] rslt;

  assign a_mag = a[OW-1] ? (~a + OW'(1)) : a;
  assign b_mag = b[OW-1] ? (~b + OW'(1)) : b;
  assign pp    = (OW+CH)'(ma) * (OW+CH)'(mb[BW-1 -: CH]);

  // floor of the signed product: round the magnitude up when negative
  always_comb begin
    rnd  = {1'b0, acc} + (neg ? RND : '0);
    q    = rnd >> FRAC_BITS;
    over = |q[PW:DW-1];
    if (neg) begin
      rslt = over ? {1'b1, {(DW-1){1'b0}}} : -q[DW-1:0];
    end else begin
      rslt = over ? {1'b0, {(DW-1){1'b1}}} : q[DW-1:0];
    end
  end

  assign stat.busy = (mstate != M_IDLE);
  assign stat.done = done;

  always_ff @(posedge clk) begin
    if (rst) begin
      mstate <= M_IDLE;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (mstate)
        M_IDLE: begin
          if (start) begin
            ma     <= a_mag;
            mb     <= BW'(b_mag);
            neg    <= a[OW-1] ^ b[OW-1];
            acc    <= '0;
            cnt    <= CW'(NCH);
            mstate <= M_RUN;
          end
        end
        M_RUN: begin
          // one chunk of the multiplier, most significant first
          acc <= (acc << CH) + PW'(pp);
          mb  <= mb << CH;
          cnt <= cnt - CW'(1);
          if (cnt == CW'(1)) mstate <= M_FIN;
        end
        M_FIN: begin
          result <= rslt;
          done   <= 1'b1;
          mstate <= M_IDLE;
        end
        default: mstate <= M_IDLE;
      endcase
    end
  end

endmodule

// ===== src/pdm_div.sv =====
module pdm_div #(
  parameter int DW        = 32,
  parameter int FRAC_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic signed [DW-1:0]          num,
  input  logic [pdm_pkg::STEP_W-1:0]    den,
  output pdm_pkg::unit_stat_t           stat,
  output logic signed [DW-1:0]          result
);
  import pdm_pkg::*;

  localparam int NW = DW + FRAC_BITS;
  localparam int CW = $clog2(NW + 1);

  localparam logic [1:0] D_IDLE = 2'd0;
  localparam logic [1:0] D_RUN  = 2'd1;
  localparam logic [1:0] D_FIN  = 2'd2;

  logic [1:0]          dstate;
  logic [NW-1:0]       dq;
  logic [STEP_W-1:0]   rem;
  logic [STEP_W-1:0]   dv;
  logic                neg;
  logic [CW-1:0]       cnt;
  logic                done;

  logic [DW-1:0]       num_mag;
  logic [STEP_W+1:0]   trial;
  logic                go;
  logic                over;
  logic signed [DW-1:0] rslt;

  assign num_mag = num[DW-1] ? (~num + DW'(1)) : num;
  assign trial   = {1'b0, rem, dq[NW-1]} - {2'b00, dv};
  assign go      = !trial[STEP_W+1];

  always_comb begin
    over = |dq[NW-1:DW-1];
    if (neg) begin
      rslt = over ? {1'b1, {(DW-1){1'b0}}} : -dq[DW-1:0];
    end else begin
      rslt = over ? {1'b0, {(DW-1){1'b1}}} : dq[DW-1:0];
    end
  end

  assign stat.busy = (dstate != D_IDLE);
  assign stat.done = done;

  always_ff @(posedge clk) begin
    if (rst) begin
      dstate <= D_IDLE;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (dstate)
        D_IDLE: begin
          if (start) begin
            dq     <= {num_mag, {FRAC_BITS{1'b0}}};
            rem    <= '0;
            dv     <= den;
            neg    <= num[DW-1];
            cnt    <= CW'(NW);
            dstate <= D_RUN;
          end
        end
        D_RUN: begin
          // restoring step, quotient bits shift in behind the dividend
          rem <= go ? trial[STEP_W-1:0] : {rem[STEP_W-2:0], dq[NW-1]};
          dq  <= {dq[NW-2:0], go};
          cnt <= cnt - CW'(1);
          if (cnt == CW'(1)) dstate <= D_FIN;
        end
        D_FIN: begin
          result <= rslt;
          done   <= 1'b1;
          dstate <= D_IDLE;
        end
        default: dstate <= D_IDLE;
      endcase
    end
  end

endmodule
